### rtl/rjp_pkg.sv
package rjp_pkg;

   // Packet sizing. A chunk carries at most PAYLOAD_LIMIT - 8 frame bytes.
   localparam int PAYLOAD_LIMIT = 1400;
   localparam int CHUNK_MAX     = PAYLOAD_LIMIT - 8;
   localparam int CHUNK_W       = $clog2(CHUNK_MAX + 1);

   // Command queue between the front and back parts (depth is a power of two).
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Configuration port.
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_IDX_W-1:0] CSR_STREAMING_ENABLE  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TCP_INTERLEAVED   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SSRC_VALUE        = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_GAP_US        = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_TIMESTAMP_STEP    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_Q_FACTOR          = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_WIDTH_DIV8        = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_HEIGHT_DIV8       = 3'd7;

   // Stream constants.
   localparam logic [7:0] JPEG_SOI_HI      = 8'hFF;
   localparam logic [7:0] JPEG_SOI_LO      = 8'hD8;
   localparam logic [7:0] RTP_VERSION_BYTE = 8'h80;
   localparam logic [6:0] RTP_PT_JPEG      = 7'd26;
   localparam logic [7:0] JPEG_TSPEC       = 8'h00;
   localparam logic [7:0] JPEG_TYPE        = 8'h01;
   localparam logic [7:0] IL_MAGIC         = 8'h24;
   localparam logic [7:0] IL_CHANNEL       = 8'h00;
   localparam int         HDR_BYTES        = 20;

   // Positions in the packet header sequence.
   localparam int               HDR_IDX_W     = 5;
   localparam logic [HDR_IDX_W-1:0] HDR_FIRST_IL  = 5'd0;
   localparam logic [HDR_IDX_W-1:0] HDR_FIRST_RTP = 5'd4;
   localparam logic [HDR_IDX_W-1:0] HDR_LAST      = 5'd23;

   typedef struct packed {
      logic [7:0]  data_byte;
      logic        frame_start;
      logic [23:0] frame_len;
      logic [47:0] now_us;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       packet_start;
      logic       packet_end;
      logic       last_of_run;
   } rsp_type;

   typedef struct packed {
      logic        streaming_enable;
      logic        tcp_interleaved;
      logic [31:0] ssrc_value;
      logic [23:0] min_gap_us;
      logic [15:0] timestamp_step;
      logic [7:0]  q_factor;
      logic [7:0]  width_div8;
      logic [7:0]  height_div8;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      streaming_enable:  1'b0,
      tcp_interleaved:   1'b0,
      ssrc_value:        32'h12345678,
      min_gap_us:        24'd100000,
      timestamp_step:    16'd9000,
      q_factor:          8'h5F,
      width_div8:        8'd40,
      height_div8:       8'd30
   };

   // One payload byte to send, with a snapshot of its packet header fields.
   typedef struct packed {
      logic [7:0]         data;
      logic               hdr;
      logic               last_chunk;
      logic [CHUNK_W-1:0] chunk;
      logic [15:0]        seq;
      logic [31:0]        rtp_time;
      logic [23:0]        offset;
      logic               pkt_end;
      logic               run_end;
   } cmd_type;

   typedef struct packed {
      logic    push0;
      logic    push1;
      cmd_type cmd0;
      cmd_type cmd1;
   } q_push_type;

   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } q_head_type;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_HOLD,
      PH_SEND
   } phase_type;

   typedef enum logic [1:0] {
      BK_SCAN,
      BK_HDR,
      BK_PAY
   } back_state_type;

endpackage

### rtl/rjp_front.sv
module rjp_front (
   input  logic                clock,
   input  logic                reset,
   input  rjp_pkg::cfg_type    cfg,
   input  logic                req_valid,
   output logic                req_stall,
   input  rjp_pkg::req_type    req_data,
   input  logic                q_room,
   output rjp_pkg::q_push_type q_push
);
   import rjp_pkg::*;

   typedef struct packed {
      logic [23:0]        bytes_left;
      logic [CHUNK_W-1:0] chunk_left;
      logic [23:0]        offset;
      logic [15:0]        seq;
   } pstate_type;

   typedef struct packed {
      pstate_type st;
      cmd_type    cmd;
   } step_type;

   // Advance the chunking state by one payload byte and build its command.
   function automatic step_type pay_step(input pstate_type cur, input logic [7:0] b,
                                         input logic [31:0] rtp);
      step_type           res;
      logic               hdr;
      logic               fits;
      logic [CHUNK_W-1:0] chunk;
      logic [CHUNK_W-1:0] cl;
      hdr   = (cur.chunk_left == '0);
      fits  = (cur.bytes_left <= 24'(CHUNK_MAX));
      chunk = fits ? cur.bytes_left[CHUNK_W-1:0] : CHUNK_W'(CHUNK_MAX);
      cl    = hdr ? chunk : cur.chunk_left;
      res.st.chunk_left  = cl - CHUNK_W'(1);
      res.st.bytes_left  = cur.bytes_left - 24'd1;
      res.st.offset      = cur.offset + 24'd1;
      res.st.seq         = cur.seq + {15'd0, hdr};
      res.cmd.data       = b;
      res.cmd.hdr        = hdr;
      res.cmd.last_chunk = fits;
      res.cmd.chunk      = chunk;
      res.cmd.seq        = cur.seq;
      res.cmd.rtp_time   = rtp;
      res.cmd.offset     = cur.offset;
      res.cmd.pkt_end    = (res.st.chunk_left == '0);
      res.cmd.run_end    = 1'b0;
      return res;
   endfunction

   phase_type   phase_ff, phase_in;
   logic [47:0] next_send_ff, next_send_in;
   logic [31:0] rtp_time_ff, rtp_time_in;
   logic [7:0]  held_ff, held_in;
   pstate_type  pst_ff, pst_in;

   pstate_type cur;
   step_type   step_a;
   step_type   step_b;
   step_type   step_s;
   logic       accept;
   logic       frame_ok;
   logic       marker_ok;

   // An item is taken whenever the queue can hold two more commands.
   assign req_stall = !q_room;
   assign accept    = req_valid && q_room;

   assign frame_ok  = cfg.streaming_enable && (req_data.frame_len >= 24'd2) &&
                      (req_data.now_us >= next_send_ff);
   assign marker_ok = (held_ff == JPEG_SOI_HI) && (req_data.data_byte == JPEG_SOI_LO);

   // The held first byte and the marker byte, or a single byte while sending.
   always_comb begin
      cur    = pst_ff;
      step_a = pay_step(cur, held_ff, rtp_time_ff);
      step_b = pay_step(step_a.st, req_data.data_byte, rtp_time_ff);
      step_s = pay_step(cur, req_data.data_byte, rtp_time_ff);
   end

   // Next state of the frame tracker.
   always_comb begin
      phase_in     = phase_ff;
      next_send_in = next_send_ff;
      rtp_time_in  = rtp_time_ff;
      held_in      = held_ff;
      pst_in       = pst_ff;
      if (accept) begin
         if (req_data.frame_start) begin
            pst_in.chunk_left = '0;
            phase_in          = PH_IDLE;
            if (frame_ok) begin
               next_send_in      = req_data.now_us + 48'(cfg.min_gap_us);
               rtp_time_in       = rtp_time_ff + 32'(cfg.timestamp_step);
               held_in           = req_data.data_byte;
               pst_in.offset     = '0;
               pst_in.bytes_left = req_data.frame_len;
               phase_in          = PH_HOLD;
            end
         end else begin
            case (phase_ff)
               PH_HOLD: begin
                  if (!marker_ok) begin
                     phase_in = PH_IDLE;
                  end else begin
                     pst_in   = step_b.st;
                     phase_in = (step_b.st.bytes_left == '0) ? PH_IDLE : PH_SEND;
                  end
               end
               PH_SEND: begin
                  if (pst_ff.bytes_left == '0) begin
                     phase_in = PH_IDLE;
                  end else begin
                     pst_in   = step_s.st;
                     phase_in = (step_s.st.bytes_left == '0) ? PH_IDLE : PH_SEND;
                  end
               end
               default: begin
                  phase_in = PH_IDLE;
               end
            endcase
         end
      end
   end

   // Commands pushed into the queue.
   always_comb begin
      q_push.push0 = 1'b0;
      q_push.push1 = 1'b0;
      q_push.cmd0  = step_s.cmd;
      q_push.cmd1  = step_b.cmd;
      q_push.cmd1.run_end = 1'b1;
      q_push.cmd0.run_end = 1'b1;
      if (accept && !req_data.frame_start) begin
         case (phase_ff)
            PH_HOLD: begin
               if (marker_ok) begin
                  q_push.push0 = 1'b1;
                  q_push.push1 = 1'b1;
                  q_push.cmd0  = step_a.cmd;
               end
            end
            PH_SEND: begin
               q_push.push0 = (pst_ff.bytes_left != '0);
            end
            default: begin
               q_push.push0 = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         next_send_ff <= '0;
         rtp_time_ff  <= '0;
         pst_ff       <= '0;
      end else begin
         phase_ff     <= phase_in;
         next_send_ff <= next_send_in;
         rtp_time_ff  <= rtp_time_in;
         pst_ff       <= pst_in;
      end
   end

   // The held byte is always written at frame start before it is read.
   always_ff @(posedge clock) begin
      held_ff <= held_in;
   end

   // A frame-start transfer never produces payload commands.
   assert property (@(posedge clock) disable iff (reset)
      (accept && req_data.frame_start) |-> !q_push.push0)
      else $error("front pushed a command on a frame start");

endmodule

### rtl/rjp_cmd_queue.sv
module rjp_cmd_queue (
   input  logic                clock,
   input  logic                reset,
   input  rjp_pkg::q_push_type q_push,
   output logic                q_room,
   input  logic                q_pop,
   output rjp_pkg::q_head_type q_head
);
   import rjp_pkg::*;

   cmd_type           entries_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic [QCNT_W-1:0] push_n;
   logic [QPTR_W-1:0] wr_ptr_next;

   // Room for a double push keeps the front free of a count-dependent path.
   assign q_room      = (count_ff <= QCNT_W'(QUEUE_DEPTH - 2));
   assign push_n      = QCNT_W'(q_push.push0) + QCNT_W'(q_push.push1);
   assign wr_ptr_next = wr_ptr_ff + QPTR_W'(1);

   assign q_head.valid = (count_ff != '0);
   assign q_head.cmd   = entries_ff[rd_ptr_ff];

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff + push_n[QPTR_W-1:0];
      rd_ptr_in = rd_ptr_ff + QPTR_W'(q_pop);
      count_in  = count_ff + push_n - QCNT_W'(q_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage needs no reset; the fill count guards it.
   always_ff @(posedge clock) begin
      if (q_push.push0) begin
         entries_ff[wr_ptr_ff] <= q_push.cmd0;
      end
      if (q_push.push1) begin
         entries_ff[wr_ptr_next] <= q_push.cmd1;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_W'(QUEUE_DEPTH))
      else $error("command queue overfilled");

   assert property (@(posedge clock) disable iff (reset)
      q_pop |-> (count_ff != '0))
      else $error("command queue popped while empty");

   assert property (@(posedge clock) disable iff (reset)
      q_push.push1 |-> (q_push.push0 && q_room))
      else $error("second push without first push or without room");

endmodule

### rtl/rjp_back.sv
module rjp_back (
   input  logic                clock,
   input  logic                reset,
   input  rjp_pkg::cfg_type    cfg,
   input  rjp_pkg::q_head_type q_head,
   output logic                q_pop,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output rjp_pkg::rsp_type    rsp_data
);
   import rjp_pkg::*;

   back_state_type       state_ff, state_in;
   logic [HDR_IDX_W-1:0] idx_ff, idx_in;
   logic                 rsp_valid_ff;
   rsp_type              rsp_data_ff;

   logic [HDR_IDX_W-1:0] start_idx;
   logic [HDR_IDX_W-1:0] cur_idx;
   logic                 emit_valid;
   logic                 emit_hdr;
   logic                 advance;
   logic [15:0]          il_len;
   logic [7:0]           hdr_byte;
   cmd_type              cmd;
   rsp_type              emit;

   assign cmd       = q_head.cmd;
   assign start_idx = cfg.tcp_interleaved ? HDR_FIRST_IL : HDR_FIRST_RTP;
   assign il_len    = 16'(HDR_BYTES) + 16'(cmd.chunk);

   // What the current state puts out.
   always_comb begin
      emit_valid = 1'b0;
      emit_hdr   = 1'b0;
      cur_idx    = start_idx;
      case (state_ff)
         BK_SCAN: begin
            emit_valid = q_head.valid;
            emit_hdr   = cmd.hdr;
            cur_idx    = start_idx;
         end
         BK_HDR: begin
            emit_valid = 1'b1;
            emit_hdr   = 1'b1;
            cur_idx    = idx_ff;
         end
         BK_PAY: begin
            emit_valid = 1'b1;
            emit_hdr   = 1'b0;
         end
         default: begin
            emit_valid = 1'b0;
         end
      endcase
   end

   // The output register takes a new byte when empty or when its byte leaves.
   assign advance = emit_valid && (!rsp_valid_ff || !rsp_stall);
   assign q_pop   = advance && !emit_hdr;

   // Interleave prefix, RTP header and JPEG header, one byte per position.
   always_comb begin
      case (cur_idx)
         5'd0:    hdr_byte = IL_MAGIC;
         5'd1:    hdr_byte = IL_CHANNEL;
         5'd2:    hdr_byte = il_len[15:8];
         5'd3:    hdr_byte = il_len[7:0];
         5'd4:    hdr_byte = RTP_VERSION_BYTE;
         5'd5:    hdr_byte = {cmd.last_chunk, RTP_PT_JPEG};
         5'd6:    hdr_byte = cmd.seq[15:8];
         5'd7:    hdr_byte = cmd.seq[7:0];
         5'd8:    hdr_byte = cmd.rtp_time[31:24];
         5'd9:    hdr_byte = cmd.rtp_time[23:16];
         5'd10:   hdr_byte = cmd.rtp_time[15:8];
         5'd11:   hdr_byte = cmd.rtp_time[7:0];
         5'd12:   hdr_byte = cfg.ssrc_value[31:24];
         5'd13:   hdr_byte = cfg.ssrc_value[23:16];
         5'd14:   hdr_byte = cfg.ssrc_value[15:8];
         5'd15:   hdr_byte = cfg.ssrc_value[7:0];
         5'd16:   hdr_byte = JPEG_TSPEC;
         5'd17:   hdr_byte = cmd.offset[23:16];
         5'd18:   hdr_byte = cmd.offset[15:8];
         5'd19:   hdr_byte = cmd.offset[7:0];
         5'd20:   hdr_byte = JPEG_TYPE;
         5'd21:   hdr_byte = cfg.q_factor;
         5'd22:   hdr_byte = cfg.width_div8;
         5'd23:   hdr_byte = cfg.height_div8;
         default: hdr_byte = 8'h00;
      endcase
   end

   always_comb begin
      emit.out_byte     = emit_hdr ? hdr_byte : cmd.data;
      emit.packet_start = emit_hdr && (cur_idx == start_idx);
      emit.packet_end   = !emit_hdr && cmd.pkt_end;
      emit.last_of_run  = !emit_hdr && cmd.run_end;
   end

   // Next state of the packet sequencer.
   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      case (state_ff)
         BK_SCAN: begin
            if (advance && emit_hdr) begin
               state_in = BK_HDR;
               idx_in   = cur_idx + HDR_IDX_W'(1);
            end
         end
         BK_HDR: begin
            if (advance) begin
               if (idx_ff == HDR_LAST) begin
                  state_in = BK_PAY;
               end else begin
                  idx_in = idx_ff + HDR_IDX_W'(1);
               end
            end
         end
         BK_PAY: begin
            if (advance) begin
               state_in = BK_SCAN;
            end
         end
         default: begin
            state_in = BK_SCAN;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_SCAN;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= emit;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // A packet in progress always has its command at the queue head.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff != BK_SCAN) |-> q_head.valid)
      else $error("packet sequencer active with an empty queue");

endmodule

### rtl/rtp_jpeg_packetizer_top.sv
// RTP/JPEG packetizer.
// Input channel (req_*): one JPEG byte per transfer, with frame_start on the
// first byte and frame_len and now_us sampled there. Result channel (rsp_*):
// one packet stream byte per transfer, marking packet start, packet end and
// the last byte caused by each input transfer. The csr_* port writes the
// eight configuration registers by index; write them only while idle.
// A front stage judges frames and cuts them into chunks, and a back stage
// expands each payload byte into header and payload bytes; a 4-entry
// command queue sits between them. The commands of an input transfer are
// registered in the queue, and each result byte in the output register.
// Payload bytes flow at one per cycle while the receiver does not stall
// and no header is being sent. At each packet start the back stage emits
// a 20-byte header (24 bytes when interleaved), one per cycle while the
// receiver does not stall. Reset is synchronous; it restores the register
// defaults, clears the frame state, sequence number and timestamp, and
// empties the queue. No clearing pass is needed. When the receiver stalls,
// the result register holds its byte, the queue fills, and req_stall rises.
module rtp_jpeg_packetizer_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic [rjp_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [rjp_pkg::CSR_DATA_W-1:0]      csr_wdata,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  rjp_pkg::req_type                    req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output rjp_pkg::rsp_type                    rsp_data
);
   import rjp_pkg::*;

   cfg_type    cfg_ff, cfg_in;
   q_push_type q_push;
   q_head_type q_head;
   logic       q_room;
   logic       q_pop;

   // Configuration register writes.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_STREAMING_ENABLE:  cfg_in.streaming_enable  = csr_wdata[0];
            CSR_TCP_INTERLEAVED:   cfg_in.tcp_interleaved   = csr_wdata[0];
            CSR_SSRC_VALUE:        cfg_in.ssrc_value        = csr_wdata[31:0];
            CSR_MIN_GAP_US:        cfg_in.min_gap_us        = csr_wdata[23:0];
            CSR_TIMESTAMP_STEP:    cfg_in.timestamp_step    = csr_wdata[15:0];
            CSR_Q_FACTOR:          cfg_in.q_factor          = csr_wdata[7:0];
            CSR_WIDTH_DIV8:        cfg_in.width_div8        = csr_wdata[7:0];
            CSR_HEIGHT_DIV8:       cfg_in.height_div8       = csr_wdata[7:0];
            default:               cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   rjp_front u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .q_room    (q_room),
      .q_push    (q_push)
   );

   rjp_cmd_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .q_push (q_push),
      .q_room (q_room),
      .q_pop  (q_pop),
      .q_head (q_head)
   );

   rjp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_head    (q_head),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
